// ===== rtl/core/fpw_pkg.sv =====
// Shared types, constants and fixed-point helpers for the flower point warp.
// Used by every module in rtl/core; depends on nothing else.
package fpw_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 20;
    localparam int ROOT_STEPS   = 32;
    localparam int DIV_BITS     = 2 * FRAC_BITS + 2;
    localparam int ANG_SHIFT    = 30 - FRAC_BITS;
    localparam int RED_SHIFT    = 40;
    localparam int LAT_SC       = CORDIC_STEPS + 6;
    localparam int NUM_REGS     = 8;

    localparam logic [2:0] REG_WEIGHT  = 3'd0;
    localparam logic [2:0] REG_PETALS  = 3'd1;
    localparam logic [2:0] REG_SPLIT   = 3'd2;
    localparam logic [2:0] REG_SPREAD  = 3'd3;
    localparam logic [2:0] REG_THICK   = 3'd4;
    localparam logic [2:0] REG_LENGTH  = 3'd5;
    localparam logic [2:0] REG_FGAIN   = 3'd6;
    localparam logic [2:0] REG_FRADIUS = 3'd7;

    localparam logic MODE_ROT = 1'b0;
    localparam logic MODE_VEC = 1'b1;

    localparam logic signed [31:0] Q_ONE   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] Q_MAX   = 32'sh7fff_ffff;
    localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
    localparam logic signed [63:0] TWO_PI_Q30  = 64'sd6746518852;
    localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
    localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;
    localparam logic signed [63:0] RED_K =
        (64'sd1 <<< (RED_SHIFT + ANG_SHIFT)) / TWO_PI_Q30;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [34:0] z;
        logic               flag;
    } cordic_t;

    typedef struct packed {
        logic [63:0] val;
        logic [35:0] rem;
        logic [31:0] root;
    } root_t;

    typedef struct packed {
        logic [DIV_BITS-1:0] num;
        logic [31:0]         rem;
        logic [31:0]         den;
        logic [DIV_BITS-1:0] quo;
        logic                neg;
        logic                zero;
    } div_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] res;
        if (v > 66'sd2147483647) begin
            res = Q_MAX;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic signed [65:0] ext66(input logic signed [31:0] v);
        return {{34{v[31]}}, v};
    endfunction

    function automatic logic signed [32:0] ext33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic signed [31:0] mulq(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
        logic signed [65:0] p;
        p = a * b;
        return sat32(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
        logic signed [34:0] v;
        case (i)
            5'd0:  v = 35'sd843314856;
            5'd1:  v = 35'sd497837829;
            5'd2:  v = 35'sd263043836;
            5'd3:  v = 35'sd133525158;
            5'd4:  v = 35'sd67021686;
            5'd5:  v = 35'sd33543515;
            5'd6:  v = 35'sd16775850;
            5'd7:  v = 35'sd8388437;
            5'd8:  v = 35'sd4194282;
            5'd9:  v = 35'sd2097149;
            5'd10: v = 35'sd1048575;
            5'd11: v = 35'sd524287;
            5'd12: v = 35'sd262143;
            5'd13: v = 35'sd131071;
            5'd14: v = 35'sd65535;
            5'd15: v = 35'sd32767;
            5'd16: v = 35'sd16383;
            5'd17: v = 35'sd8191;
            5'd18: v = 35'sd4095;
            5'd19: v = 35'sd2047;
            5'd20: v = 35'sd1023;
            5'd21: v = 35'sd511;
            5'd22: v = 35'sd255;
            5'd23: v = 35'sd127;
            5'd24: v = 35'sd63;
            5'd25: v = 35'sd31;
            5'd26: v = 35'sd15;
            5'd27: v = 35'sd7;
            5'd28: v = 35'sd3;
            5'd29: v = 35'sd1;
            default: v = 35'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] reg_reset(input logic [2:0] i);
        logic signed [31:0] v;
        case (i)
            REG_PETALS: v = Q_ONE * 6;
            REG_SPLIT, REG_LENGTH, REG_FGAIN: v = 32'sd0;
            default: v = Q_ONE;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/flower_point_warp.sv =====
// Flower warp of one flame point in signed Q16.16, fully pipelined.
// Each point accepted on start comes out with done set and its result; one point
// is taken every cycle and busy stays low, since the result side cannot stall.
// The latency is set by the atan2 and sine rows, the divider row and the root row.
// Reset clears the valid pipeline and loads the registers with their defaults.
// Depends on fpw_pkg, fpw_cordic_cell, fpw_root_cell, fpw_div_cell, fpw_sincos.
module flower_point_warp (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] src_x,
    input  logic signed [31:0] src_y,
    input  logic signed [31:0] acc_x,
    input  logic signed [31:0] acc_y,
    input  logic signed [31:0] acc_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    localparam int P_IN     = 1;
    localparam int P_T      = 3 + fpw_pkg::CORDIC_STEPS;
    localparam int P_SC_OUT = P_T + 2 + fpw_pkg::LAT_SC;
    localparam int P_MAG    = 3 + fpw_pkg::ROOT_STEPS;
    localparam int P_R0     = P_MAG + 1;
    localparam int P_R      = P_SC_OUT + 4;
    localparam int P_P      = P_R + 1;
    localparam int P_O      = P_P + 1;
    localparam int P_Q      = P_P + fpw_pkg::DIV_BITS + 1;
    localparam int P_OUT    = P_Q + 5;
    localparam int D_R0     = P_R - 1 - P_R0;
    localparam int D_SC     = P_R - P_SC_OUT;
    localparam int D_ACC    = P_Q + 1;
    localparam int D_OX     = P_OUT - 1 - P_O;
    localparam int TAP_AXY  = P_P - P_IN - 1;
    localparam int TAP_AZ   = P_Q;

    logic signed [31:0] cfg_reg [fpw_pkg::NUM_REGS];
    logic [P_OUT-1:0]   vld_reg;
    logic               accept;

    logic signed [31:0] sx_reg, sy_reg, ax_reg, ay_reg, az_reg;
    logic [63:0]        sqx_reg, sqy_reg, sum_reg;
    fpw_pkg::cordic_t   at_init_reg;
    fpw_pkg::root_t     mag_chain [fpw_pkg::ROOT_STEPS+1];
    fpw_pkg::cordic_t   at_chain [fpw_pkg::CORDIC_STEPS+1];
    logic signed [31:0] t_reg, t_d1_reg, t_d2_reg, pt_reg, pt_d1_reg, sp_reg;
    logic signed [31:0] s1, c1, s2, c2, st, ct;
    logic signed [31:0] r0_reg;
    logic signed [31:0] r0_dly_reg [D_R0];
    logic signed [63:0] sc_dly_reg [D_SC];
    logic signed [95:0] acc_dly_reg [D_ACC];
    logic signed [31:0] sum1_reg, c2_d_reg, m_reg, mabs_reg, r_reg;
    logic signed [31:0] px_reg, py_reg, ox_reg, oy_reg;
    logic signed [63:0] ox_dly_reg [D_OX];
    fpw_pkg::div_t      div_chain [fpw_pkg::DIV_BITS+1];
    fpw_pkg::div_t      div_init_reg;
    logic [63:0]        sq2x_reg, sq2y_reg, sum2_reg;
    fpw_pkg::root_t     rn_chain [fpw_pkg::ROOT_STEPS+1];
    logic signed [31:0] q_reg, qm1_reg, ex_reg, tz_reg, fz_reg, fz_d_reg;
    logic               gt_reg, gt_d1_reg, gt_d2_reg;
    logic signed [31:0] oz1_reg, oz2_reg;
    logic signed [31:0] outx_reg, outy_reg, outz_reg;
    logic signed [65:0] quo_s;
    logic signed [31:0] lim;
    logic signed [31:0] st_p, ct_p, ax_t, ay_t, az_t;
    logic [31:0]        rnew;
    logic               at_zero;

    assign accept    = start & ~busy;
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < fpw_pkg::NUM_REGS; k++)
            begin
                cfg_reg[k] <= fpw_pkg::reg_reset(3'(k));
            end
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
            vld_reg <= {vld_reg[P_OUT-2:0], accept};
        end
    end

    always_comb
    begin
        at_zero = (sx_reg == 32'sd0) && (sy_reg == 32'sd0);
    end

    // Front end: operand capture, squares, and the atan2 pre-rotation.
    always_ff @(posedge clk)
    begin
        sx_reg  <= src_x;
        sy_reg  <= src_y;
        ax_reg  <= acc_x;
        ay_reg  <= acc_y;
        az_reg  <= acc_z;
        sqx_reg <= 64'(sx_reg * sx_reg);
        sqy_reg <= 64'(sy_reg * sy_reg);
        sum_reg <= sqx_reg + sqy_reg;
        at_init_reg.flag <= at_zero;
        if (sy_reg < 32'sd0)
        begin
            at_init_reg.x <= -({{32{sy_reg[31]}}, sy_reg} <<< 29);
            at_init_reg.y <= -({{32{sx_reg[31]}}, sx_reg} <<< 29);
            at_init_reg.z <= (sx_reg >= 32'sd0) ? 35'(fpw_pkg::PI_Q30)
                                                : -35'(fpw_pkg::PI_Q30);
        end
        else
        begin
            at_init_reg.x <= {{32{sy_reg[31]}}, sy_reg} <<< 29;
            at_init_reg.y <= {{32{sx_reg[31]}}, sx_reg} <<< 29;
            at_init_reg.z <= 35'sd0;
        end
    end

    assign mag_chain[0] = '{val: sum_reg, rem: 36'd0, root: 32'd0};
    assign at_chain[0]  = at_init_reg;

    for (genvar i = 0; i < fpw_pkg::ROOT_STEPS; i++)
    begin : g_mag
        fpw_root_cell u_cell (
            .clk   (clk),
            .d_in  (mag_chain[i]),
            .d_out (mag_chain[i+1])
        );
    end

    for (genvar i = 0; i < fpw_pkg::CORDIC_STEPS; i++)
    begin : g_atan
        fpw_cordic_cell u_cell (
            .clk      (clk),
            .mode_vec (fpw_pkg::MODE_VEC),
            .step     (5'(i)),
            .d_in     (at_chain[i]),
            .d_out    (at_chain[i+1])
        );
    end

    // Angle products feeding the three sine/cosine rows, aligned at their inputs.
    always_ff @(posedge clk)
    begin
        t_reg     <= at_chain[fpw_pkg::CORDIC_STEPS].flag ? 32'sd0
                   : 32'(at_chain[fpw_pkg::CORDIC_STEPS].z >>> fpw_pkg::ANG_SHIFT);
        t_d1_reg  <= t_reg;
        t_d2_reg  <= t_d1_reg;
        pt_reg    <= fpw_pkg::mulq(fpw_pkg::ext33(cfg_reg[fpw_pkg::REG_PETALS]),
                                   fpw_pkg::ext33(t_reg));
        pt_d1_reg <= pt_reg;
        sp_reg    <= fpw_pkg::mulq(fpw_pkg::ext33(cfg_reg[fpw_pkg::REG_SPLIT]),
                                   fpw_pkg::ext33(pt_reg));
        r0_reg    <= fpw_pkg::mulq(fpw_pkg::ext33(cfg_reg[fpw_pkg::REG_WEIGHT]),
                                   {1'b0, mag_chain[fpw_pkg::ROOT_STEPS].root});
    end

    fpw_sincos u_sc_t (
        .clk   (clk),
        .angle (t_d2_reg),
        .sin_q (st),
        .cos_q (ct)
    );

    fpw_sincos u_sc_pt (
        .clk   (clk),
        .angle (pt_d1_reg),
        .sin_q (s1),
        .cos_q (c1)
    );

    fpw_sincos u_sc_sp (
        .clk   (clk),
        .angle (sp_reg),
        .sin_q (s2),
        .cos_q (c2)
    );

    always_ff @(posedge clk)
    begin
        r0_dly_reg[0]  <= r0_reg;
        for (int k = 1; k < D_R0; k++)
        begin
            r0_dly_reg[k] <= r0_dly_reg[k-1];
        end
        sc_dly_reg[0]  <= {st, ct};
        for (int k = 1; k < D_SC; k++)
        begin
            sc_dly_reg[k] <= sc_dly_reg[k-1];
        end
        acc_dly_reg[0] <= {ax_reg, ay_reg, az_reg};
        for (int k = 1; k < D_ACC; k++)
        begin
            acc_dly_reg[k] <= acc_dly_reg[k-1];
        end
        ox_dly_reg[0]  <= {ox_reg, oy_reg};
        for (int k = 1; k < D_OX; k++)
        begin
            ox_dly_reg[k] <= ox_dly_reg[k-1];
        end
    end

    always_comb
    begin
        st_p = sc_dly_reg[D_SC-1][63:32];
        ct_p = sc_dly_reg[D_SC-1][31:0];
        ax_t = acc_dly_reg[TAP_AXY][95:64];
        ay_t = acc_dly_reg[TAP_AXY][63:32];
        az_t = acc_dly_reg[TAP_AZ][31:0];
    end

    // Petal radius, planar offset and the divider launch.
    always_ff @(posedge clk)
    begin
        sum1_reg <= fpw_pkg::sat32(fpw_pkg::ext66(cfg_reg[fpw_pkg::REG_SPREAD])
                                   + fpw_pkg::ext66(s1));
        c2_d_reg <= c2;
        m_reg    <= fpw_pkg::mulq(fpw_pkg::ext33(sum1_reg), fpw_pkg::ext33(c2_d_reg));
        mabs_reg <= (m_reg < 32'sd0) ? fpw_pkg::sat32(-fpw_pkg::ext66(m_reg)) : m_reg;
        r_reg    <= fpw_pkg::mulq(fpw_pkg::ext33(r0_dly_reg[D_R0-1]),
                                  fpw_pkg::ext33(mabs_reg));
        px_reg   <= fpw_pkg::mulq(fpw_pkg::ext33(st_p), fpw_pkg::ext33(r_reg));
        py_reg   <= fpw_pkg::mulq(fpw_pkg::ext33(ct_p), fpw_pkg::ext33(r_reg));
        ox_reg   <= fpw_pkg::sat32(fpw_pkg::ext66(ax_t) + fpw_pkg::ext66(px_reg));
        oy_reg   <= fpw_pkg::sat32(fpw_pkg::ext66(ay_t) + fpw_pkg::ext66(py_reg));
        div_init_reg.num  <= {1'b1, {(fpw_pkg::DIV_BITS-1){1'b0}}};
        div_init_reg.rem  <= 32'd0;
        div_init_reg.den  <= (r_reg < 32'sd0) ? 32'(-r_reg) : 32'(r_reg);
        div_init_reg.quo  <= '0;
        div_init_reg.neg  <= r_reg[31];
        div_init_reg.zero <= (r_reg == 32'sd0);
        sq2x_reg <= 64'(ox_reg * ox_reg);
        sq2y_reg <= 64'(oy_reg * oy_reg);
        sum2_reg <= sq2x_reg + sq2y_reg;
    end

    assign div_chain[0] = div_init_reg;
    assign rn_chain[0]  = '{val: sum2_reg, rem: 36'd0, root: 32'd0};

    for (genvar i = 0; i < fpw_pkg::DIV_BITS; i++)
    begin : g_div
        fpw_div_cell u_cell (
            .clk   (clk),
            .d_in  (div_chain[i]),
            .d_out (div_chain[i+1])
        );
    end

    for (genvar i = 0; i < fpw_pkg::ROOT_STEPS; i++)
    begin : g_rnew
        fpw_root_cell u_cell (
            .clk   (clk),
            .d_in  (rn_chain[i]),
            .d_out (rn_chain[i+1])
        );
    end

    always_comb
    begin
        quo_s = {{(66-fpw_pkg::DIV_BITS){1'b0}}, div_chain[fpw_pkg::DIV_BITS].quo};
        if (div_chain[fpw_pkg::DIV_BITS].neg)
        begin
            quo_s = -quo_s;
        end
        rnew = rn_chain[fpw_pkg::ROOT_STEPS].root;
        lim  = fpw_pkg::sat32(-fpw_pkg::ext66(cfg_reg[fpw_pkg::REG_LENGTH]));
    end

    // Stem pull, fold and length clamp on z.
    always_ff @(posedge clk)
    begin
        q_reg     <= div_chain[fpw_pkg::DIV_BITS].zero ? fpw_pkg::Q_MAX
                                                       : fpw_pkg::sat32(quo_s);
        qm1_reg   <= fpw_pkg::sat32(fpw_pkg::ext66(q_reg) - fpw_pkg::ext66(fpw_pkg::Q_ONE));
        ex_reg    <= fpw_pkg::sat32({34'd0, rnew}
                                    - fpw_pkg::ext66(cfg_reg[fpw_pkg::REG_FRADIUS]));
        gt_reg    <= $signed({34'd0, rnew}) > fpw_pkg::ext66(cfg_reg[fpw_pkg::REG_FRADIUS]);
        tz_reg    <= fpw_pkg::mulq(fpw_pkg::ext33(cfg_reg[fpw_pkg::REG_THICK]),
                                   fpw_pkg::ext33(qm1_reg));
        fz_reg    <= fpw_pkg::mulq(fpw_pkg::ext33(ex_reg),
                                   fpw_pkg::ext33(cfg_reg[fpw_pkg::REG_FGAIN]));
        gt_d1_reg <= gt_reg;
        oz1_reg   <= fpw_pkg::sat32(fpw_pkg::ext66(az_t) - fpw_pkg::ext66(tz_reg));
        fz_d_reg  <= fz_reg;
        gt_d2_reg <= gt_d1_reg;
        oz2_reg   <= gt_d2_reg ? fpw_pkg::sat32(fpw_pkg::ext66(oz1_reg)
                                                + fpw_pkg::ext66(fz_d_reg))
                               : oz1_reg;
        if ((cfg_reg[fpw_pkg::REG_LENGTH] != 32'sd0) && (oz2_reg <= lim))
        begin
            outz_reg <= lim;
        end
        else
        begin
            outz_reg <= oz2_reg;
        end
        outx_reg  <= ox_dly_reg[D_OX-1][63:32];
        outy_reg  <= ox_dly_reg[D_OX-1][31:0];
    end

    assign done  = vld_reg[P_OUT-1];
    assign out_x = outx_reg;
    assign out_y = outy_reg;
    assign out_z = outz_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##P_OUT done)
        else $error("accepted point did not complete on schedule");

    a_x_align: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_x == $past(ox_reg, P_OUT - P_O))
        else $error("x result misaligned with its point");

    a_div_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[P_R-1] && r_reg == 32'sd0) |-> ##(P_Q - P_R) q_reg == fpw_pkg::Q_MAX)
        else $error("zero radius did not saturate the quotient");

endmodule

// ===== rtl/core/fpw_cordic_cell.sv =====
// One CORDIC micro-rotation, registered, in rotation or vectoring mode.
// Depends on fpw_pkg for the state type and the arctangent table.
module fpw_cordic_cell (
    input  logic             clk,
    input  logic             mode_vec,
    input  logic [4:0]       step,
    input  fpw_pkg::cordic_t d_in,
    output fpw_pkg::cordic_t d_out
);

    fpw_pkg::cordic_t   cell_reg;
    fpw_pkg::cordic_t   cell_next;
    logic signed [63:0] xi;
    logic signed [63:0] yi;
    logic signed [34:0] zi;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    logic signed [34:0] da;
    logic               pos;

    always_comb
    begin
        xi  = d_in.x;
        yi  = d_in.y;
        zi  = d_in.z;
        dx  = yi >>> step;
        dy  = xi >>> step;
        da  = fpw_pkg::atan_q30(step);
        pos = mode_vec ? yi[63] : ~zi[34];
        cell_next.flag = d_in.flag;
        if (pos)
        begin
            cell_next.x = xi - dx;
            cell_next.y = yi + dy;
            cell_next.z = zi - da;
        end
        else
        begin
            cell_next.x = xi + dx;
            cell_next.y = yi - dy;
            cell_next.z = zi + da;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign d_out = cell_reg;

endmodule

// ===== rtl/core/fpw_root_cell.sv =====
// One bit of a pipelined integer square root of a 64-bit value.
// Depends on fpw_pkg for the root_t stage type.
module fpw_root_cell (
    input  logic           clk,
    input  fpw_pkg::root_t d_in,
    output fpw_pkg::root_t d_out
);

    fpw_pkg::root_t cell_reg;
    fpw_pkg::root_t cell_next;
    logic [35:0]    rem_sh;
    logic [35:0]    trial;

    always_comb
    begin
        rem_sh = {d_in.rem[33:0], d_in.val[63:62]};
        trial  = {2'b00, d_in.root, 2'b01};
        cell_next.val = {d_in.val[61:0], 2'b00};
        if (rem_sh >= trial)
        begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {d_in.root[30:0], 1'b1};
        end
        else
        begin
            cell_next.rem  = rem_sh;
            cell_next.root = {d_in.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign d_out = cell_reg;

endmodule

// ===== rtl/core/fpw_div_cell.sv =====
// One quotient bit of a pipelined restoring divider with a fixed dividend.
// Depends on fpw_pkg for the div_t stage type.
module fpw_div_cell (
    input  logic          clk,
    input  fpw_pkg::div_t d_in,
    output fpw_pkg::div_t d_out
);

    fpw_pkg::div_t cell_reg;
    fpw_pkg::div_t cell_next;
    logic [32:0]   rem_sh;

    always_comb
    begin
        rem_sh = {d_in.rem, d_in.num[fpw_pkg::DIV_BITS-1]};
        cell_next      = d_in;
        cell_next.num  = {d_in.num[fpw_pkg::DIV_BITS-2:0], 1'b0};
        if (rem_sh >= {1'b0, d_in.den})
        begin
            cell_next.rem = 32'(rem_sh - {1'b0, d_in.den});
            cell_next.quo = {d_in.quo[fpw_pkg::DIV_BITS-2:0], 1'b1};
        end
        else
        begin
            cell_next.rem = rem_sh[31:0];
            cell_next.quo = {d_in.quo[fpw_pkg::DIV_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign d_out = cell_reg;

endmodule

// ===== rtl/core/fpw_sincos.sv =====
// Pipelined sine and cosine of a Q16.16 angle: range reduction, then a row of
// CORDIC rotation cells. Depends on fpw_pkg and fpw_cordic_cell.
module fpw_sincos (
    input  logic               clk,
    input  logic signed [31:0] angle,
    output logic signed [31:0] sin_q,
    output logic signed [31:0] cos_q
);

    logic signed [47:0] z0_reg;
    logic signed [15:0] qe_reg;
    logic signed [47:0] rem2_reg;
    logic signed [47:0] rem3_reg;
    logic signed [47:0] w_reg;
    fpw_pkg::cordic_t   init_reg;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;
    logic signed [63:0] ang64;
    logic signed [63:0] prod;
    logic signed [63:0] qmul;
    logic signed [47:0] wf;
    logic               flip;
    logic signed [63:0] cx;
    fpw_pkg::cordic_t   chain [fpw_pkg::CORDIC_STEPS+1];

    always_comb
    begin
        ang64 = {{32{angle[31]}}, angle};
        prod  = ang64 * fpw_pkg::RED_K;
        qmul  = {{48{qe_reg[15]}}, qe_reg} * fpw_pkg::TWO_PI_Q30;
        if (w_reg > 48'(fpw_pkg::HALF_PI_Q30))
        begin
            wf   = 48'(fpw_pkg::PI_Q30) - w_reg;
            flip = 1'b1;
        end
        else if (w_reg < -48'(fpw_pkg::HALF_PI_Q30))
        begin
            wf   = -48'(fpw_pkg::PI_Q30) - w_reg;
            flip = 1'b1;
        end
        else
        begin
            wf   = w_reg;
            flip = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        z0_reg   <= 48'(ang64 <<< fpw_pkg::ANG_SHIFT);
        qe_reg   <= 16'(prod >>> fpw_pkg::RED_SHIFT);
        rem2_reg <= z0_reg - 48'(qmul);
        if (rem2_reg < 48'sd0)
        begin
            rem3_reg <= rem2_reg + 48'(fpw_pkg::TWO_PI_Q30);
        end
        else if (rem2_reg >= 48'(fpw_pkg::TWO_PI_Q30))
        begin
            rem3_reg <= rem2_reg - 48'(fpw_pkg::TWO_PI_Q30);
        end
        else
        begin
            rem3_reg <= rem2_reg;
        end
        if (rem3_reg >= 48'(fpw_pkg::PI_Q30))
        begin
            w_reg <= rem3_reg - 48'(fpw_pkg::TWO_PI_Q30);
        end
        else
        begin
            w_reg <= rem3_reg;
        end
        init_reg.x    <= fpw_pkg::GAIN_Q30;
        init_reg.y    <= 64'sd0;
        init_reg.z    <= 35'(wf);
        init_reg.flag <= flip;
    end

    assign chain[0] = init_reg;

    for (genvar i = 0; i < fpw_pkg::CORDIC_STEPS; i++)
    begin : g_cell
        fpw_cordic_cell u_cell (
            .clk      (clk),
            .mode_vec (fpw_pkg::MODE_ROT),
            .step     (5'(i)),
            .d_in     (chain[i]),
            .d_out    (chain[i+1])
        );
    end

    always_comb
    begin
        cx = chain[fpw_pkg::CORDIC_STEPS].flag ? -chain[fpw_pkg::CORDIC_STEPS].x
                                               : chain[fpw_pkg::CORDIC_STEPS].x;
    end

    always_ff @(posedge clk)
    begin
        sin_reg <= 32'(chain[fpw_pkg::CORDIC_STEPS].y >>> fpw_pkg::ANG_SHIFT);
        cos_reg <= 32'(cx >>> fpw_pkg::ANG_SHIFT);
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule
